@@ hdl/graph_hop_distance_bfs_macros.svh @@
// Assertion helpers shared by the hop-distance search block.
`ifndef GRAPH_HOP_DISTANCE_BFS_MACROS_SVH
`define GRAPH_HOP_DISTANCE_BFS_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, sampled on clk, off while rst_n is low
`define GHD_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ghd assertion failed");
// next-cycle implication
`define GHD_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ghd assertion failed");
`else
`define GHD_ASSERT_IMP(name, ante, cons)
`define GHD_ASSERT_NEXT(name, ante, cons)
`endif
`endif

@@ hdl/ghd_pkg.sv @@
`default_nettype none

package ghd_pkg;

    localparam int NODE_W = 4;
    localparam int DIST_W = 4;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic              command;
        logic [NODE_W-1:0] first_node;
        logic [NODE_W-1:0] second_node;
    } ghd_request_t;

    typedef struct packed {
        logic              reachable;
        logic [DIST_W-1:0] distance;
    } ghd_response_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture request fields
        logic rd_en;      // adjacency row read
        logic rd_second;  // read row of second_node instead of first_node
        logic wr_en;      // adjacency row write
        logic wr_second;  // write row of second_node instead of first_node
        logic q_init;     // seed search with start node
        logic q_step;     // expand one frontier node
        logic q_advance;  // move to next level
        logic finish;     // load response register
        logic found;      // response is a hit
    } ghd_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic range_bad;
        logic frontier_empty;
        logic target_hit;
        logic scan_done;
        logic out_free;
    } ghd_status_t;

endpackage

`default_nettype wire

@@ hdl/ghd_datapath.sv @@
`default_nettype none
`include "graph_hop_distance_bfs_macros.svh"

module ghd_datapath
    import ghd_pkg::*;
#(
    parameter int MAX_NODES = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire ghd_request_t  request,
    input  wire ghd_cmd_t      cmd,
    output ghd_status_t        status,
    input  wire logic          response_ready,
    output logic               response_valid,
    output ghd_response_t      response
);

    localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

    logic [NODE_W-1:0]    first_reg;
    logic [NODE_W-1:0]    second_reg;
    logic [IDX_W-1:0]     first_idx;
    logic [IDX_W-1:0]     second_idx;

    // adjacency rows; valid bits stand in for the reset clear
    logic [MAX_NODES-1:0] adj_mem [MAX_NODES];
    logic [MAX_NODES-1:0] row_valid_reg;
    logic [MAX_NODES-1:0] adj_rdata_reg;
    logic                 row_ok_reg;
    logic [MAX_NODES-1:0] row_eff;
    logic [IDX_W-1:0]     rd_addr;
    logic [IDX_W-1:0]     wr_addr;
    logic [MAX_NODES-1:0] wr_data;
    logic [MAX_NODES-1:0] first_mask;
    logic [MAX_NODES-1:0] second_mask;

    // level-synchronous search state
    logic [MAX_NODES-1:0] frontier_reg;
    logic [MAX_NODES-1:0] nxt_reg;
    logic [MAX_NODES-1:0] visited_reg;
    logic                 pend_reg;
    logic [DIST_W-1:0]    level_reg;
    logic [IDX_W-1:0]     pick_idx;

    logic                 resp_valid_reg;
    ghd_response_t        resp_data_reg;

    assign first_idx  = IDX_W'(first_reg);
    assign second_idx = IDX_W'(second_reg);

    always_comb
    begin
        first_mask              = '0;
        second_mask             = '0;
        first_mask[first_idx]   = 1'b1;
        second_mask[second_idx] = 1'b1;
    end

    // lowest set frontier bit
    always_comb
    begin
        pick_idx = '0;
        for (int i = MAX_NODES - 1; i >= 0; i--)
        begin
            if (frontier_reg[i])
            begin
                pick_idx = IDX_W'(i);
            end
        end
    end

    assign row_eff = row_ok_reg ? adj_rdata_reg : '0;
    assign rd_addr = cmd.q_step ? pick_idx : (cmd.rd_second ? second_idx : first_idx);
    assign wr_addr = cmd.wr_second ? second_idx : first_idx;
    assign wr_data = row_eff | (cmd.wr_second ? first_mask : second_mask);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            first_reg  <= request.first_node;
            second_reg <= request.second_node;
        end
        if (cmd.rd_en)
        begin
            adj_rdata_reg <= adj_mem[rd_addr];
        end
        if (cmd.wr_en)
        begin
            adj_mem[wr_addr] <= wr_data;
        end
        if (cmd.finish)
        begin
            resp_data_reg.reachable <= cmd.found;
            resp_data_reg.distance  <= cmd.found ? level_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg  <= '0;
            row_ok_reg     <= 1'b0;
            frontier_reg   <= '0;
            nxt_reg        <= '0;
            visited_reg    <= '0;
            pend_reg       <= 1'b0;
            level_reg      <= '0;
            resp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.rd_en)
            begin
                row_ok_reg <= row_valid_reg[rd_addr];
            end
            if (cmd.wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end

            if (cmd.q_init)
            begin
                frontier_reg <= first_mask;
                visited_reg  <= first_mask;
                nxt_reg      <= '0;
                pend_reg     <= 1'b0;
                level_reg    <= '0;
            end
            else if (cmd.q_advance)
            begin
                frontier_reg <= nxt_reg;
                nxt_reg      <= '0;
                level_reg    <= level_reg + 1'b1;
            end
            else if (cmd.q_step)
            begin
                if (pend_reg)
                begin
                    nxt_reg     <= nxt_reg | (row_eff & ~visited_reg);
                    visited_reg <= visited_reg | row_eff;
                end
                pend_reg     <= (frontier_reg != '0);
                frontier_reg <= frontier_reg & (frontier_reg - 1'b1);
            end

            if (cmd.finish)
            begin
                resp_valid_reg <= 1'b1;
            end
            else if (response_ready)
            begin
                resp_valid_reg <= 1'b0;
            end
        end
    end

    assign status.range_bad      = (32'(first_reg) >= MAX_NODES) ||
                                   (32'(second_reg) >= MAX_NODES);
    assign status.frontier_empty = (frontier_reg == '0);
    assign status.target_hit     = frontier_reg[second_idx];
    assign status.scan_done      = (frontier_reg == '0) && !pend_reg;
    assign status.out_free       = !resp_valid_reg || response_ready;

    assign response_valid = resp_valid_reg;
    assign response       = resp_data_reg;

    `GHD_ASSERT_IMP(a_frontier_visited, 1'b1, (frontier_reg & ~visited_reg) == '0)
    `GHD_ASSERT_IMP(a_next_visited, 1'b1, (nxt_reg & ~visited_reg) == '0)
    `GHD_ASSERT_NEXT(a_resp_loaded, cmd.finish, resp_valid_reg)

endmodule

`default_nettype wire

@@ hdl/ghd_ctrl.sv @@
`default_nettype none
`include "graph_hop_distance_bfs_macros.svh"

module ghd_ctrl
    import ghd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        request_valid,
    input  wire logic        request_command,
    output logic             request_ready,
    input  wire ghd_status_t status,
    output ghd_cmd_t         cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_WA,
        S_ADD_WB,
        S_Q_INIT,
        S_Q_CHECK,
        S_Q_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (request_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = (request_command == CMD_ADD) ? S_ADD_RD : S_Q_INIT;
                end
            end
            S_ADD_RD:
            begin
                if (status.range_bad)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_ADD_WA;
                end
            end
            S_ADD_WA:
            begin
                cmd.wr_en     = 1'b1;
                cmd.rd_en     = 1'b1;
                cmd.rd_second = 1'b1;
                state_next    = S_ADD_WB;
            end
            S_ADD_WB:
            begin
                cmd.wr_en     = 1'b1;
                cmd.wr_second = 1'b1;
                state_next    = S_IDLE;
            end
            S_Q_INIT:
            begin
                if (status.range_bad)
                begin
                    if (status.out_free)
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.q_init = 1'b1;
                    state_next = S_Q_CHECK;
                end
            end
            S_Q_CHECK:
            begin
                priority if (status.frontier_empty || status.target_hit)
                begin
                    if (status.out_free)
                    begin
                        cmd.finish = 1'b1;
                        cmd.found  = status.target_hit;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_Q_SCAN;
                end
            end
            S_Q_SCAN:
            begin
                if (status.scan_done)
                begin
                    cmd.q_advance = 1'b1;
                    state_next    = S_Q_CHECK;
                end
                else
                begin
                    cmd.q_step = 1'b1;
                    cmd.rd_en  = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign request_ready = (state_reg == S_IDLE);

    `GHD_ASSERT_IMP(a_finish_free, cmd.finish, status.out_free)
    `GHD_ASSERT_IMP(a_write_in_add, cmd.wr_en, (state_reg == S_ADD_WA) || (state_reg == S_ADD_WB))
    `GHD_ASSERT_IMP(a_load_on_accept, cmd.load, request_valid && request_ready)

endmodule

`default_nettype wire

@@ hdl/graph_hop_distance_bfs.sv @@
// Hop distance in an undirected graph of up to MAX_NODES nodes.
// request channel (valid/ready): command 0 adds edge first_node--second_node,
//   command 1 asks the hop count from first_node to second_node.
// response channel (valid/ready): one transaction per query, none per add;
//   reachable = 0 and distance = 0 when no path exists or a node is out of range.
// Sequencing: an add is a read-modify-write of both adjacency rows. A query
//   searches level by level, expanding one frontier node per cycle through the
//   single adjacency-row read, and loads its response once the target is in
//   the frontier or the frontier is empty. One request is in flight at a time.
// The response register decouples the sides: a new request is accepted while a
//   result still waits; a query only stalls at completion if the previous
//   response has not been taken yet.
// Reset (rst_n, async, active low) empties the graph at once through per-row
//   valid bits and drops any pending response; no clearing sweep is needed.
// Distance is reported modulo 16.
`default_nettype none

module graph_hop_distance_bfs
    import ghd_pkg::*;
#(
    parameter int MAX_NODES = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          request_valid,
    output logic               request_ready,
    input  wire ghd_request_t  request,
    output logic               response_valid,
    input  wire logic          response_ready,
    output ghd_response_t      response
);

    ghd_cmd_t    cmd;
    ghd_status_t status;

    // sequencer: add read-modify-write, then level-by-level search
    ghd_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .request_valid   (request_valid),
        .request_command (request.command),
        .request_ready   (request_ready),
        .status          (status),
        .cmd             (cmd)
    );

    // adjacency memory, frontier/visited masks, level counter, response register
    ghd_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .request        (request),
        .cmd            (cmd),
        .status         (status),
        .response_ready (response_ready),
        .response_valid (response_valid),
        .response       (response)
    );

endmodule

`default_nettype wire

@@ sim/ghd_hop_checker.sv @@
`timescale 1ns / 100ps

// Watches both channels of the hop-distance block, keeps its own copy of the
// graph, and predicts every query result with a breadth-first search.
module ghd_hop_checker
    import ghd_pkg::*;
#(
    parameter int MAX_NODES = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          request_valid,
    input  logic          request_ready,
    input  ghd_request_t  request,
    input  logic          response_valid,
    input  logic          response_ready,
    input  ghd_response_t response,
    output int            mismatch_count,
    output int            hops_waiting,
    output int            edges_added,
    output int            queries_seen,
    output int            hits_seen,
    output int            longest_hop
);

    logic [MAX_NODES-1:0] graph_rows [MAX_NODES];
    ghd_response_t        expected_hops [$];
    ghd_response_t        next_hop;
    int                   reports_left = 200;

    // BFS over the shadow graph; distance wraps to the 4-bit field
    function automatic ghd_response_t hop_distance(input int start, input int target);
        ghd_response_t        res;
        logic [MAX_NODES-1:0] seen;
        int                   fifo [MAX_NODES];
        int                   level [MAX_NODES];
        int                   head;
        int                   tail;
        int                   node;
        res = '0;
        if (start >= MAX_NODES || target >= MAX_NODES)
            return res;
        seen        = '0;
        seen[start] = 1'b1;
        level[start] = 0;
        fifo[0]     = start;
        head        = 0;
        tail        = 1;
        while (head < tail) begin
            node = fifo[head];
            head++;
            if (node == target) begin
                res.reachable = 1'b1;
                res.distance  = DIST_W'(level[node]);
                return res;
            end
            for (int nb = 0; nb < MAX_NODES; nb++) begin
                if (graph_rows[node][nb] && !seen[nb]) begin
                    seen[nb]    = 1'b1;
                    level[nb]   = level[node] + 1;
                    fifo[tail]  = nb;
                    tail++;
                end
            end
        end
        return res;
    endfunction

    task automatic report_field(input string field, input int want, input int got);
        mismatch_count++;
        if (reports_left > 0) begin
            reports_left--;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int r = 0; r < MAX_NODES; r++)
                graph_rows[r] <= '0;
            expected_hops.delete();
        end
        else begin
            // response first: a result can never belong to a query taken this edge
            if (response_valid && response_ready) begin
                if (expected_hops.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected response, expected none, got reachable=%0d distance=%0d",
                             $time, response.reachable, response.distance);
                end
                else begin
                    next_hop = expected_hops.pop_front();
                    if (next_hop.reachable !== response.reachable)
                        report_field("reachable", next_hop.reachable, response.reachable);
                    if (next_hop.distance !== response.distance)
                        report_field("distance", next_hop.distance, response.distance);
                end
            end
            if (request_valid && request_ready) begin
                if (request.command == CMD_QUERY) begin
                    next_hop = hop_distance(request.first_node, request.second_node);
                    expected_hops.push_back(next_hop);
                    queries_seen++;
                    if (next_hop.reachable) begin
                        hits_seen++;
                        if (next_hop.distance > longest_hop)
                            longest_hop = next_hop.distance;
                    end
                end
                else begin
                    if (request.first_node < MAX_NODES && request.second_node < MAX_NODES) begin
                        graph_rows[request.first_node][request.second_node] = 1'b1;
                        graph_rows[request.second_node][request.first_node] = 1'b1;
                    end
                    edges_added++;
                end
            end
        end
        hops_waiting = expected_hops.size();
    end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

// Top of the hop-distance testbench. This module only makes stimulus and
// gives the verdict; ghd_hop_checker watches both channels and predicts.
//
// Stimulus plan:
//   - directed: queries on the empty graph (no path, node to itself), a self
//     edge, a duplicate edge, then a chain 0-1-...-15 so the longest possible
//     hop count (15) shows up in both directions.
//   - random: mostly queries with a trickle of new edges, so the graph fills
//     in slowly and BFS depth stays interesting for a long stretch.
// Both sides idle at random; now and then a calm stretch runs with no idling.
module testbench
    import ghd_pkg::*;
();

    localparam int RANDOM_ITEMS = 1625;
    localparam int DRAIN_CYCLES = 64;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          request_valid = 1'b0;
    logic          request_ready;
    ghd_request_t  request = '0;
    logic          response_valid;
    logic          response_ready = 1'b0;
    ghd_response_t response;

    bit            calm = 1'b0;          // no idling on either side while set
    int            ready_hold = 0;

    int            mismatch_count;
    int            hops_waiting;
    int            edges_added;
    int            queries_seen;
    int            hits_seen;
    int            longest_hop;

    always #1 clk = ~clk;

    graph_hop_distance_bfs u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .request_valid (request_valid),
        .request_ready (request_ready),
        .request       (request),
        .response_valid(response_valid),
        .response_ready(response_ready),
        .response      (response)
    );

    ghd_hop_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .request_valid (request_valid),
        .request_ready (request_ready),
        .request       (request),
        .response_valid(response_valid),
        .response_ready(response_ready),
        .response      (response),
        .mismatch_count(mismatch_count),
        .hops_waiting  (hops_waiting),
        .edges_added   (edges_added),
        .queries_seen  (queries_seen),
        .hits_seen     (hits_seen),
        .longest_hop   (longest_hop)
    );

    // Idle length: mostly none or short, a few long ones.
    function automatic int idle_cycles();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 50)
            return 0;
        else if (roll < 88)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Response side back-pressure: ready drops for a random stretch now and then.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            response_ready <= 1'b0;
            ready_hold     <= 0;
        end
        else if (ready_hold != 0) begin
            response_ready <= 1'b0;
            ready_hold     <= ready_hold - 1;
        end
        else begin
            response_ready <= 1'b1;
            if ($urandom_range(0, 99) < 25)
                ready_hold <= idle_cycles();
        end
    end

    // One request transaction. Called at a rising edge; returns at the edge
    // where it was accepted, with valid still high so a back-to-back
    // transaction can follow without a glitch.
    task automatic send_request(input logic cmd, input logic [NODE_W-1:0] a,
                                input logic [NODE_W-1:0] b);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            request_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        request_valid       <= 1'b1;
        request.command     <= cmd;
        request.first_node  <= a;
        request.second_node <= b;
        @(posedge clk);
        while (!request_ready)
            @(posedge clk);
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty graph: nothing reachable except a node from itself
        send_request(CMD_QUERY, 4'd0, 4'd15);
        send_request(CMD_QUERY, 4'd9, 4'd9);
        // self edge must not change any distance
        send_request(CMD_ADD, 4'd3, 4'd3);
        send_request(CMD_QUERY, 4'd3, 4'd3);
        send_request(CMD_ADD, 4'd5, 4'd6);
        send_request(CMD_QUERY, 4'd5, 4'd6);
        send_request(CMD_QUERY, 4'd6, 4'd7);
        // chain across all nodes; 5-6 is already there, so that one is a duplicate
        for (int n = 0; n < 15; n++) begin
            if (n % 2 == 0)
                send_request(CMD_ADD, NODE_W'(n), NODE_W'(n + 1));
            else
                send_request(CMD_ADD, NODE_W'(n + 1), NODE_W'(n));
        end
        send_request(CMD_ADD, 4'd1, 4'd0);
        send_request(CMD_QUERY, 4'd0, 4'd15);
        send_request(CMD_QUERY, 4'd15, 4'd0);

        // random part: sparse edge growth keeps long paths around for a while
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 100 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 2)
                send_request(CMD_ADD, NODE_W'($urandom_range(0, 15)),
                             NODE_W'($urandom_range(0, 15)));
            else
                send_request(CMD_QUERY, NODE_W'($urandom_range(0, 15)),
                             NODE_W'($urandom_range(0, 15)));
        end
        request_valid <= 1'b0;
        calm = 1'b0;

        while (hops_waiting != 0)
            @(posedge clk);
        // let any stray response show up before judging
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d edge adds and %0d hop queries", edges_added, queries_seen);
        $display("  %0d queries reached their target, longest hop count %0d",
                 hits_seen, longest_hop);
        if (mismatch_count == 0 && hops_waiting == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog: a time limit of several times the slowest legal run.
    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
